[hw/rtl/sclt_pkg.sv]
// sclt_pkg: payload types, character constants and result codes for the
// command line tokenizer; no dependencies
`default_nettype none

package sclt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_RES           = 4;
    localparam int BUN_DEPTH         = 2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
        logic [15:0] error_position;
        logic        last_of_run;
    } result_t;

    localparam logic [2:0] KIND_BYTE = 3'd0;
    localparam logic [2:0] KIND_WEND = 3'd1;
    localparam logic [2:0] KIND_CEND = 3'd2;
    localparam logic [2:0] KIND_DONE = 3'd3;
    localparam logic [2:0] KIND_FAIL = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OPEN_SQ   = 3'd1;
    localparam logic [2:0] ERR_OPEN_DQ   = 3'd2;
    localparam logic [2:0] ERR_OPEN_ESC  = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
    localparam logic [2:0] ERR_BAD_OCT   = 3'd5;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd6;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF_LC = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LX    = 8'h78;

    // bit 4 set marks a byte that is no hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= CH_ZERO && c <= CH_NINE)
            v = {1'b0, 4'(c - CH_ZERO)};
        else if (c >= CH_UA && c <= CH_UF)
            v = {1'b0, 4'(c - CH_UA + 8'd10)};
        else if (c >= CH_LA && c <= CH_LF_LC)
            v = {1'b0, 4'(c - CH_LA + 8'd10)};
        return v;
    endfunction

    // bit 3 set marks a byte that is no octal digit
    function automatic logic [3:0] oct_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h8;
        if (c >= CH_ZERO && c <= CH_SEVEN)
            v = {1'b0, 3'(c - CH_ZERO)};
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic result_t mk_res(input logic [2:0] k, input logic [7:0] d,
                                       input logic [2:0] e, input logic [15:0] p);
        result_t r;
        r.kind           = k;
        r.data_byte      = d;
        r.error_code     = e;
        r.error_position = p;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/shell_command_line_tokenizer.sv]
// shell_command_line_tokenizer: splits a byte stream into words, commands
// and errors; input register, one-pass parse, two-bundle result buffer
// depends on sclt_pkg
//
//   channel  | signals                            | moves per transfer
//   ---------+------------------------------------+----------------------------
//   item     | item_valid, item_stall, item       | one line byte, end flag
//   result   | result_valid, result_stall, result | one result of a byte's run
//
// a byte waits in the input register until the result buffer has room; a byte
// with n results (n from 0 to 4) gives one per transfer; bytes with at most
// one result flow at one per cycle unless stalled; result port sets the pace
// reset clears the parser state, input register and buffer at once
// item_stall rises only while the two-entry result buffer is full
`default_nettype none

module shell_command_line_tokenizer #(
    parameter int POSITION_BITS = sclt_pkg::POSITION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire sclt_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output sclt_pkg::result_t      result
);
    import sclt_pkg::*;

    localparam int PE     = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam int PTR_W  = (BUN_DEPTH > 1) ? $clog2(BUN_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUN_DEPTH + 1);
    localparam int SUB_W  = $clog2(MAX_RES);
    localparam int N_W    = $clog2(MAX_RES + 1);

    typedef enum logic [3:0] {
        M_NORMAL,
        M_SQ,
        M_DQ,
        M_DQ_ESC,
        M_HEX1,
        M_HEX2,
        M_OCT1,
        M_OCT2,
        M_BARE,
        M_BARE_CR,
        M_SWALLOW
    } mode_t;

    mode_t                     mode_reg, mode_next;
    logic                      wopen_reg, wopen_next;
    logic [3:0]                held_reg, held_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [POSITION_BITS-1:0]  esc_reg, esc_next;

    logic                      in_vld_reg;
    item_t                     in_reg;

    result_t                   bun_res_reg [BUN_DEPTH][MAX_RES];
    logic [SUB_W-1:0]          bun_last_reg [BUN_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [SUB_W-1:0]          sub_reg, sub_next;

    result_t                   res [MAX_RES];
    logic [N_W-1:0]            n;
    logic                      room, process, push, pop_res, pop_bun;

    logic [POSITION_BITS-1:0]  len;
    logic [15:0]               pos16, len16, esc16;
    logic [7:0]                c;
    logic                      eol, do_normal;
    logic [4:0]                hv;
    logic [3:0]                ov;

    assign c     = in_reg.char_byte;
    assign eol   = in_reg.end_of_line;
    assign len   = (pos_reg != {POSITION_BITS{1'b1}}) ? pos_reg + 1'b1 : pos_reg;
    assign pos16 = 16'(PE'(pos_reg));
    assign len16 = 16'(PE'(len));
    assign esc16 = 16'(PE'(esc_reg));
    assign hv    = hex_val(c);
    assign ov    = oct_val(c);

    assign room       = cnt_reg < CNT_W'(BUN_DEPTH);
    assign item_stall = in_vld_reg && !room;
    assign process    = in_vld_reg && room;
    assign push       = process && (n != '0);

    assign result_valid = cnt_reg != '0;
    assign result       = bun_res_reg[rd_ptr_reg][sub_reg];
    assign pop_res      = result_valid && !result_stall;
    assign pop_bun      = pop_res && (sub_reg == bun_last_reg[rd_ptr_reg]);

    // per-byte parse
    always_comb
    begin
        mode_next  = mode_reg;
        wopen_next = wopen_reg;
        held_next  = held_reg;
        esc_next   = esc_reg;
        n          = '0;
        do_normal  = 1'b0;
        for (int i = 0; i < MAX_RES; i++)
            res[i] = mk_res(KIND_BYTE, 8'h00, ERR_NONE, 16'h0000);

        case (mode_reg)
            M_NORMAL:
                do_normal = 1'b1;
            M_SQ:
                if (c == CH_SQ)
                    mode_next = M_NORMAL;
                else
                begin
                    res[SUB_W'(n)] = mk_res(KIND_BYTE, c, ERR_NONE, 16'h0000);
                    n = n + 1'b1;
                    wopen_next = 1'b1;
                end
            M_DQ:
                if (c == CH_DQ)
                    mode_next = M_NORMAL;
                else if (c == CH_BSL)
                    mode_next = M_DQ_ESC;
                else
                begin
                    res[SUB_W'(n)] = mk_res(KIND_BYTE, c, ERR_NONE, 16'h0000);
                    n = n + 1'b1;
                    wopen_next = 1'b1;
                end
            M_DQ_ESC:
                if (c == CH_LX)
                begin
                    esc_next  = pos_reg;
                    mode_next = M_HEX1;
                end
                else if (c == CH_ZERO)
                begin
                    esc_next  = pos_reg;
                    mode_next = M_OCT1;
                end
                else if (c == CH_LT || c == CH_LR || c == CH_LN || c == CH_LB)
                begin
                    res[0] = mk_res(KIND_BYTE, CH_BSL, ERR_NONE, 16'h0000);
                    res[1] = mk_res(KIND_BYTE, c, ERR_NONE, 16'h0000);
                    n = N_W'(2);
                    wopen_next = 1'b1;
                    mode_next  = M_DQ;
                end
                else
                begin
                    res[0] = mk_res(KIND_FAIL, 8'h00, ERR_BAD_ESC, pos16);
                    n = N_W'(1);
                    mode_next = M_SWALLOW;
                end
            M_HEX1:
                if (eol)
                begin
                    res[0] = mk_res(KIND_FAIL, 8'h00, ERR_OPEN_DQ, len16);
                    n = N_W'(1);
                    mode_next = M_SWALLOW;
                end
                else if (hv[4])
                begin
                    res[0] = mk_res(KIND_FAIL, 8'h00, ERR_BAD_HEX, esc16);
                    n = N_W'(1);
                    mode_next = M_SWALLOW;
                end
                else
                begin
                    held_next = hv[3:0];
                    mode_next = M_HEX2;
                end
            M_OCT1:
                if (eol)
                begin
                    res[0] = mk_res(KIND_FAIL, 8'h00, ERR_OPEN_DQ, len16);
                    n = N_W'(1);
                    mode_next = M_SWALLOW;
                end
                else if (ov[3])
                begin
                    res[0] = mk_res(KIND_FAIL, 8'h00, ERR_BAD_OCT, esc16);
                    n = N_W'(1);
                    mode_next = M_SWALLOW;
                end
                else
                begin
                    held_next = ov;
                    mode_next = M_OCT2;
                end
            M_HEX2:
                if (hv[4])
                begin
                    res[0] = mk_res(KIND_FAIL, 8'h00, ERR_BAD_HEX, esc16);
                    n = N_W'(1);
                    mode_next = M_SWALLOW;
                end
                else
                begin
                    res[0] = mk_res(KIND_BYTE, {held_reg, hv[3:0]}, ERR_NONE, 16'h0000);
                    n = N_W'(1);
                    wopen_next = 1'b1;
                    held_next  = 4'h0;
                    mode_next  = M_DQ;
                end
            M_OCT2:
                if (ov[3])
                begin
                    res[0] = mk_res(KIND_FAIL, 8'h00, ERR_BAD_OCT, esc16);
                    n = N_W'(1);
                    mode_next = M_SWALLOW;
                end
                else
                begin
                    res[0] = mk_res(KIND_BYTE, {2'b00, held_reg[2:0], ov[2:0]},
                                    ERR_NONE, 16'h0000);
                    n = N_W'(1);
                    wopen_next = 1'b1;
                    held_next  = 4'h0;
                    mode_next  = M_DQ;
                end
            M_BARE:
                if (c == CH_LF)
                    mode_next = M_NORMAL;
                else if (c == CH_CR)
                    mode_next = M_BARE_CR;
                else
                begin
                    res[0] = mk_res(KIND_BYTE, c, ERR_NONE, 16'h0000);
                    n = N_W'(1);
                    wopen_next = 1'b1;
                    mode_next  = M_NORMAL;
                end
            M_BARE_CR:
            begin
                mode_next = M_NORMAL;
                if (c != CH_LF)
                begin
                    res[0] = mk_res(KIND_BYTE, CH_CR, ERR_NONE, 16'h0000);
                    n = N_W'(1);
                    wopen_next = 1'b1;
                    do_normal  = 1'b1;
                end
            end
            default:
                mode_next = M_SWALLOW;
        endcase

        // plain byte outside quotes
        if (do_normal)
        begin
            if (c == CH_SEMI || is_space(c))
            begin
                if (wopen_next)
                begin
                    res[SUB_W'(n)] = mk_res(KIND_WEND, 8'h00, ERR_NONE, 16'h0000);
                    n = n + 1'b1;
                end
                wopen_next = 1'b0;
                if (c == CH_SEMI)
                begin
                    res[SUB_W'(n)] = mk_res(KIND_CEND, 8'h00, ERR_NONE, 16'h0000);
                    n = n + 1'b1;
                end
            end
            else if (c == CH_SQ)
                mode_next = M_SQ;
            else if (c == CH_DQ)
                mode_next = M_DQ;
            else if (c == CH_BSL)
                mode_next = M_BARE;
            else
            begin
                res[SUB_W'(n)] = mk_res(KIND_BYTE, c, ERR_NONE, 16'h0000);
                n = n + 1'b1;
                wopen_next = 1'b1;
            end
        end

        // line end
        if (eol)
        begin
            case (mode_next)
                M_NORMAL, M_BARE_CR:
                begin
                    if (mode_next == M_BARE_CR)
                    begin
                        res[SUB_W'(n)] = mk_res(KIND_BYTE, CH_CR, ERR_NONE, 16'h0000);
                        n = n + 1'b1;
                        wopen_next = 1'b1;
                    end
                    if (wopen_next)
                    begin
                        res[SUB_W'(n)] = mk_res(KIND_WEND, 8'h00, ERR_NONE, 16'h0000);
                        n = n + 1'b1;
                    end
                    res[SUB_W'(n)] = mk_res(KIND_DONE, 8'h00, ERR_NONE, 16'h0000);
                    n = n + 1'b1;
                end
                M_SQ:
                begin
                    res[SUB_W'(n)] = mk_res(KIND_FAIL, 8'h00, ERR_OPEN_SQ, len16);
                    n = n + 1'b1;
                end
                M_BARE:
                begin
                    res[SUB_W'(n)] = mk_res(KIND_FAIL, 8'h00, ERR_OPEN_ESC, len16);
                    n = n + 1'b1;
                end
                M_SWALLOW:
                    n = n;
                default:
                begin
                    res[SUB_W'(n)] = mk_res(KIND_FAIL, 8'h00, ERR_OPEN_DQ, len16);
                    n = n + 1'b1;
                end
            endcase
            mode_next  = M_NORMAL;
            wopen_next = 1'b0;
            held_next  = 4'h0;
            esc_next   = '0;
            pos_next   = '0;
        end
        else
            pos_next = len;

        if (n != '0)
            res[SUB_W'(n - 1'b1)].last_of_run = 1'b1;
    end

    // buffer pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(BUN_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_bun)
        begin
            sub_next    = '0;
            rd_ptr_next = (rd_ptr_reg == PTR_W'(BUN_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        else if (pop_res)
            sub_next = sub_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop_bun);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_NORMAL;
            wopen_reg  <= 1'b0;
            held_reg   <= 4'h0;
            pos_reg    <= '0;
            esc_reg    <= '0;
            in_vld_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            if (process)
            begin
                mode_reg  <= mode_next;
                wopen_reg <= wopen_next;
                held_reg  <= held_next;
                pos_reg   <= pos_next;
                esc_reg   <= esc_next;
            end
            if (!item_stall)
                in_vld_reg <= item_valid;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (!item_stall)
            in_reg <= item;
        if (push)
        begin
            for (int i = 0; i < MAX_RES; i++)
                bun_res_reg[wr_ptr_reg][i] <= res[i];
            bun_last_reg[wr_ptr_reg] <= SUB_W'(n - 1'b1);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(BUN_DEPTH))
        else $error("result buffer overfilled");

    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_FAIL) |-> result.last_of_run)
        else $error("failure not last of its run");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_DONE) |-> result.last_of_run)
        else $error("line done not last of its run");

    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last_of_run) |=> result_valid)
        else $error("run broken before its last result");

endmodule

`default_nettype wire
